/* rtl/bal_pkg.sv */
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list engine.
// ----------------------------------------------------------------------------
package bal_pkg;

  // List geometry
  localparam int CAPACITY   = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Request field widths
  localparam int OP_W  = 3;
  localparam int POS_W = 4;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT    = 3'd0,
    OP_DELETE_AT    = 3'd1,
    OP_INSERT_KEY   = 3'd2,
    OP_DELETE_FIRST = 3'd3,
    OP_DELETE_ALL   = 3'd4,
    OP_READ_AT      = 3'd5,
    OP_WRITE_AT     = 3'd6
  } op_e;

  // How a request is carried out after the precheck
  typedef enum logic [1:0] {
    KIND_FAIL  = 2'd0,
    KIND_SCAN  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted request
    logic decode;    // latch request kind, arm the scan
    logic scan_run;  // issue next scan read, process previous entry
    logic access;    // single read or write at the position
    logic res_load;  // commit list length, fill output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;        // kind of the latched request (valid in decode)
    logic  scan_empty;  // scan has no entries to visit
    logic  proc_last;   // last scanned entry is being processed
  } status_t;

endpackage

/* rtl/bounded_array_list_engine.sv */
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of up to eight signed 32-bit entries with seven operations.
// ----------------------------------------------------------------------------
// One request is taken at a time and yields one result item. Read and write
// at a position go from decode to a single access of the entry RAM. Shifting
// inserts, deletes and key searches make one pass over the entry RAM, one
// entry per cycle through its single read and single write port; the pass
// covers the list length for deletes and the length plus one for inserts.
// Failed prechecks, and deletes on an empty list, skip the pass. A finished
// result waits in the output register while the next request is accepted.
module bounded_array_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: [2:0] op, [6:3] position, [38:7] search_key,
  //          [70:39] new_value, [71] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  // result: [0] ok, [32:1] read_value, [36:33] list_length,
  //         [40:37] removed_count, [47:41] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata
);
  import bal_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    ok;
  data_t   read_value;
  cnt_t    list_length, removed_count;

  // Sequencer
  bal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // List datapath
  bal_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (s_axis_tdata[2:0]),
    .position_i      (s_axis_tdata[6:3]),
    .search_key_i    (s_axis_tdata[38:7]),
    .new_value_i     (s_axis_tdata[70:39]),
    .ok_o            (ok),
    .read_value_o    (read_value),
    .list_length_o   (list_length),
    .removed_count_o (removed_count)
  );

  assign m_axis_tdata = {7'd0, removed_count, list_length, read_value, ok};

endmodule

/* rtl/bal_ram.sv */
// ----------------------------------------------------------------------------
// bal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bal_ctrl.sv */
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: accepts an item, steps the datapath through the
// precheck, the entry scan or single access, and hands off the result.
// ----------------------------------------------------------------------------
module bal_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bal_pkg::status_t status_i,
  output bal_pkg::cmd_t    cmd_o
);
  import bal_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_ACCESS = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        unique case (status_i.kind)
          KIND_FAIL:  state_d = S_DONE;
          KIND_SCAN:  state_d = status_i.scan_empty ? S_DONE : S_SCAN;
          KIND_READ:  state_d = S_ACCESS;
          KIND_WRITE: state_d = S_ACCESS;
          default:    state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.proc_last) begin
          state_d = S_DONE;
        end
      end
      S_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/bal_dpath.sv */
// ----------------------------------------------------------------------------
// bal_dpath
// List datapath: entry RAM, length counter, request registers, the
// one-pass scan engine for shifting inserts and compacting deletes, and
// the output register.
// ----------------------------------------------------------------------------
module bal_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bal_pkg::cmd_t    cmd_i,
  output bal_pkg::status_t status_o,
  input  logic [2:0]       op_i,
  input  bal_pkg::pos_t    position_i,
  input  bal_pkg::data_t   search_key_i,
  input  bal_pkg::data_t   new_value_i,
  output logic             ok_o,
  output bal_pkg::data_t   read_value_o,
  output bal_pkg::cnt_t    list_length_o,
  output bal_pkg::cnt_t    removed_count_o
);
  import bal_pkg::*;

  // Request registers
  op_e   op_q;
  pos_t  pos_q;
  data_t key_q, val_q;
  idx_t  pos_idx;

  // List state and scan control
  cnt_t  count_q, count_d;
  kind_e kind_q, kind_d;
  idx_t  rd_ptr_q, rd_ptr_d;
  idx_t  proc_idx_q, proc_idx_d;
  logic  proc_valid_q, proc_valid_d;
  logic  issue_more_q, issue_more_d;
  logic  ins_q, ins_d;
  data_t held_q, held_d;
  cnt_t  wr_ptr_q, wr_ptr_d;
  cnt_t  removed_q, removed_d;

  // Output register
  logic  ok_q;
  data_t rdval_q;
  cnt_t  len_q, rem_q;

  // RAM ports
  logic  ram_we, ram_re;
  idx_t  ram_waddr, ram_raddr;
  data_t ram_wdata, ram_rdata;

  logic  is_ins;
  cnt_t  cnt_m1;
  idx_t  last_idx;
  logic  hit, skip, key_eq;

  assign pos_idx  = pos_q[IDX_W-1:0];
  assign is_ins   = (op_q == OP_INSERT_AT) || (op_q == OP_INSERT_KEY);
  assign cnt_m1   = count_q - cnt_t'(1);
  // Inserts visit one slot past the end to take the shifted-out entry
  assign last_idx = is_ins ? count_q[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
  assign key_eq   = (ram_rdata == key_q);

  // Precheck of the latched request against the current length
  always_comb begin
    unique case (op_q)
      OP_INSERT_AT:
        kind_d = (count_q < cnt_t'(CAPACITY) && cnt_t'(pos_q) <= count_q) ?
                 KIND_SCAN : KIND_FAIL;
      OP_INSERT_KEY:
        kind_d = (count_q < cnt_t'(CAPACITY)) ? KIND_SCAN : KIND_FAIL;
      OP_DELETE_AT:
        kind_d = (cnt_t'(pos_q) < count_q) ? KIND_SCAN : KIND_FAIL;
      OP_DELETE_FIRST, OP_DELETE_ALL:
        kind_d = KIND_SCAN;
      OP_READ_AT:
        kind_d = (cnt_t'(pos_q) < count_q) ? KIND_READ : KIND_FAIL;
      OP_WRITE_AT:
        kind_d = (cnt_t'(pos_q) < count_q) ? KIND_WRITE : KIND_FAIL;
      default:
        kind_d = KIND_FAIL;
    endcase
  end

  assign status_o.kind       = kind_d;
  assign status_o.scan_empty = !is_ins && (count_q == '0);
  assign status_o.proc_last  = proc_valid_q && (proc_idx_q == last_idx);

  // Scan engine: read entry i while entry i-1 is shifted or compacted
  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    proc_idx_d   = proc_idx_q;
    proc_valid_d = proc_valid_q;
    issue_more_d = issue_more_q;
    ins_d        = ins_q;
    held_d       = held_q;
    wr_ptr_d     = wr_ptr_q;
    removed_d    = removed_q;
    count_d      = count_q;
    ram_we       = 1'b0;
    ram_waddr    = proc_idx_q;
    ram_wdata    = held_q;
    ram_re       = 1'b0;
    ram_raddr    = rd_ptr_q;
    hit          = 1'b0;
    skip         = 1'b0;

    if (cmd_i.decode) begin
      rd_ptr_d     = '0;
      proc_valid_d = 1'b0;
      issue_more_d = 1'b1;
      ins_d        = 1'b0;
      wr_ptr_d     = '0;
      removed_d    = '0;
    end

    if (cmd_i.scan_run) begin
      // read issue stage
      proc_valid_d = issue_more_q;
      if (issue_more_q) begin
        ram_re     = 1'b1;
        proc_idx_d = rd_ptr_q;
        rd_ptr_d   = rd_ptr_q + idx_t'(1);
        if (rd_ptr_q == last_idx) begin
          issue_more_d = 1'b0;
        end
      end
      // process stage
      if (proc_valid_q) begin
        if (is_ins) begin
          if (op_q == OP_INSERT_AT) begin
            hit = !ins_q && (proc_idx_q == pos_idx);
          end else begin
            hit = !ins_q && (cnt_t'(proc_idx_q) < count_q) && key_eq;
          end
          if (hit) begin
            ram_we    = 1'b1;
            ram_wdata = val_q;
            held_d    = ram_rdata;
            ins_d     = 1'b1;
          end else if (ins_q) begin
            ram_we    = 1'b1;
            ram_wdata = held_q;
            held_d    = ram_rdata;
          end
        end else begin
          skip = ((op_q == OP_DELETE_AT) && (proc_idx_q == pos_idx)) ||
                 ((op_q == OP_DELETE_FIRST) && (removed_q == '0) && key_eq) ||
                 ((op_q == OP_DELETE_ALL) && key_eq);
          if (skip) begin
            removed_d = removed_q + cnt_t'(1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_q[IDX_W-1:0];
            ram_wdata = ram_rdata;
            wr_ptr_d  = wr_ptr_q + cnt_t'(1);
          end
        end
      end
    end

    // single positional access
    if (cmd_i.access) begin
      ram_raddr = pos_idx;
      ram_re    = (kind_q == KIND_READ);
      ram_waddr = pos_idx;
      ram_wdata = val_q;
      ram_we    = (kind_q == KIND_WRITE);
    end

    // new length after a scan
    if (cmd_i.res_load && kind_q == KIND_SCAN) begin
      count_d = is_ins ? (count_q + cnt_t'(ins_q)) : wr_ptr_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      kind_q       <= KIND_FAIL;
      proc_valid_q <= 1'b0;
      issue_more_q <= 1'b0;
      ins_q        <= 1'b0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      removed_q    <= '0;
    end else begin
      count_q      <= count_d;
      proc_valid_q <= proc_valid_d;
      issue_more_q <= issue_more_d;
      ins_q        <= ins_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      removed_q    <= removed_d;
      if (cmd_i.decode) begin
        kind_q <= kind_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    proc_idx_q <= proc_idx_d;
    held_q     <= held_d;
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      pos_q <= position_i;
      key_q <= search_key_i;
      val_q <= new_value_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      len_q <= count_d;
      unique case (kind_q)
        KIND_FAIL: begin
          ok_q    <= 1'b0;
          rdval_q <= '0;
          rem_q   <= '0;
        end
        KIND_READ: begin
          ok_q    <= 1'b1;
          rdval_q <= ram_rdata;
          rem_q   <= '0;
        end
        KIND_WRITE: begin
          ok_q    <= 1'b1;
          rdval_q <= '0;
          rem_q   <= '0;
        end
        KIND_SCAN: begin
          rdval_q <= '0;
          if (is_ins) begin
            ok_q  <= ins_q;
            rem_q <= '0;
          end else begin
            ok_q  <= (op_q == OP_DELETE_FIRST) ? (removed_q != '0) : 1'b1;
            rem_q <= removed_q;
          end
        end
        default: begin
          ok_q    <= 1'b0;
          rdval_q <= '0;
          rem_q   <= '0;
        end
      endcase
    end
  end

  assign ok_o            = ok_q;
  assign read_value_o    = rdval_q;
  assign list_length_o   = len_q;
  assign removed_count_o = rem_q;

  // Entry storage
  bal_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded array list engine. Requests are streamed
// in through the slave port while a shadow copy of the list predicts each
// result. Results from the master port are compared field by field in order.
// Directed runs cover the empty list, the full list, the value extremes and
// bad positions. Random traffic follows, in two of three runs with random stalls on both ports.
// ----------------------------------------------------------------------------
module tb_top;
  import bal_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int LEN_W         = 4;
  // op code left unused by the block
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic             ok;
    data_t            rd;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] removed;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // request: op, position, search_key, new_value, zero pad
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // result: ok, read_value, list_length, removed_count, zero pad
  logic [47:0] m_axis_tdata;

  // Shadow of the list contents
  data_t        shadow_entries [CAPACITY];
  int unsigned  shadow_len;

  list_result_t expected_results_q [$];
  list_result_t seen_result;
  list_result_t want_result;
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;
  int unsigned  stall_left;
  bit           idle_on;
  bit           fill_mode;

  bounded_array_list_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit shadow_insert(int unsigned p, data_t v);
    if (shadow_len >= CAPACITY || p > shadow_len) return 1'b0;
    for (int unsigned i = shadow_len; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[p] = v;
    shadow_len++;
    return 1'b1;
  endfunction

  function automatic bit shadow_delete(int unsigned p);
    if (p >= shadow_len) return 1'b0;
    for (int unsigned i = p; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_len--;
    return 1'b1;
  endfunction

  function automatic bit shadow_find(data_t key, output int unsigned at);
    at = 0;
    for (int unsigned i = 0; i < shadow_len; i++) begin
      if (shadow_entries[i] == key) begin
        at = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow list and returns the result it should give
  function automatic list_result_t apply_request(logic [OP_W-1:0] op, pos_t pos,
                                                 data_t key, data_t val);
    list_result_t res;
    int unsigned  at;
    int unsigned  w;
    res.ok      = 1'b0;
    res.rd      = '0;
    res.removed = '0;
    case (op)
      OP_INSERT_AT: res.ok = shadow_insert(pos, val);
      OP_DELETE_AT: begin
        res.ok = shadow_delete(pos);
        if (res.ok) res.removed = LEN_W'(1);
      end
      OP_INSERT_KEY: begin
        if (shadow_find(key, at)) res.ok = shadow_insert(at, val);
      end
      OP_DELETE_FIRST: begin
        if (shadow_find(key, at)) res.ok = shadow_delete(at);
        if (res.ok) res.removed = LEN_W'(1);
      end
      OP_DELETE_ALL: begin
        // compact survivors toward the front
        w = 0;
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (shadow_entries[i] == key) begin
            res.removed = res.removed + LEN_W'(1);
          end else begin
            shadow_entries[w] = shadow_entries[i];
            w++;
          end
        end
        shadow_len = w;
        res.ok     = 1'b1;
      end
      OP_READ_AT: begin
        if (pos < shadow_len) begin
          res.rd = shadow_entries[pos];
          res.ok = 1'b1;
        end
      end
      OP_WRITE_AT: begin
        if (pos < shadow_len) begin
          shadow_entries[pos] = val;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.len = shadow_len[LEN_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic log_failure(string msg);
    if (fail_cnt < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // Drives one request and records its prediction once accepted
  task automatic send_request(logic [OP_W-1:0] op, pos_t pos, data_t key, data_t val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, key, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results_q.push_back(apply_request(op, pos, key, val));
    @(negedge clk_i);
  endtask

  // Holds off new requests until every outstanding result is back
  task automatic settle_list();
    s_axis_tvalid <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- result side

  // Receiver stalls
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result.ok      = m_axis_tdata[0];
      seen_result.rd      = m_axis_tdata[32:1];
      seen_result.len     = m_axis_tdata[36:33];
      seen_result.removed = m_axis_tdata[40:37];
      if (expected_results_q.size() == 0) begin
        log_failure($sformatf("unexpected result ok=%0b rd=%h len=%0d removed=%0d",
                              seen_result.ok, seen_result.rd, seen_result.len,
                              seen_result.removed));
      end else begin
        want_result = expected_results_q.pop_front();
        if (seen_result.ok !== want_result.ok || seen_result.rd !== want_result.rd ||
            seen_result.len !== want_result.len ||
            seen_result.removed !== want_result.removed) begin
          log_failure($sformatf(
            "mismatch: exp ok=%0b rd=%h len=%0d removed=%0d, got ok=%0b rd=%h len=%0d removed=%0d",
            want_result.ok, want_result.rd, want_result.len, want_result.removed,
            seen_result.ok, seen_result.rd, seen_result.len, seen_result.removed));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Reads, deletes, a key insert and the unused op code against an empty list
  task automatic test_empty_list();
    send_request(OP_READ_AT,      4'd0, '0, '0);
    send_request(OP_DELETE_AT,    4'd0, '0, '0);
    send_request(OP_DELETE_FIRST, 4'd0, '0, '0);
    send_request(OP_DELETE_ALL,   4'd0, '0, '0);
    send_request(OP_INSERT_KEY,   4'd0, '0, 32'd1);
    send_request(OP_UNUSED,       4'd0, '0, '0);
    settle_list();
  endtask

  // Build up to capacity with value extremes, then try to overflow
  task automatic test_fill_to_capacity();
    send_request(OP_INSERT_AT,  4'd1, '0, 32'd1);            // past the end
    send_request(OP_INSERT_AT,  4'd0, '0, 32'h8000_0000);
    send_request(OP_INSERT_AT,  4'd1, '0, 32'h7fff_ffff);
    send_request(OP_INSERT_AT,  4'd0, '0, 32'd5);            // front shift
    send_request(OP_INSERT_AT,  4'd3, '0, 32'd5);            // append
    send_request(OP_INSERT_AT,  4'd2, '0, 32'd5);            // middle shift
    send_request(OP_INSERT_KEY, 4'd0, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_INSERT_AT,  4'd6, '0, 32'd0);
    send_request(OP_INSERT_AT,  4'd7, '0, 32'd5);            // now full
    send_request(OP_INSERT_AT,  4'd0, '0, 32'd1);
    send_request(OP_INSERT_KEY, 4'd0, 32'd5, 32'd1);
    settle_list();
  endtask

  // Positions at and past the end, key removals on a full list
  task automatic test_bounds_and_keys();
    send_request(OP_READ_AT,      4'd7,  '0, '0);
    send_request(OP_READ_AT,      4'd8,  '0, '0);
    send_request(OP_WRITE_AT,     4'd7,  '0, 32'h8000_0001);
    send_request(OP_WRITE_AT,     4'd8,  '0, 32'h1234_5678);
    send_request(OP_DELETE_ALL,   4'd0,  32'd5, '0);          // several matches
    send_request(OP_DELETE_FIRST, 4'd0,  32'h7fff_ffff, '0);
    send_request(OP_DELETE_FIRST, 4'd0,  32'd5, '0);          // no match left
    send_request(OP_DELETE_AT,    4'd15, '0, '0);
    send_request(OP_DELETE_AT,    4'd0,  '0, '0);
    settle_list();
  endtask

  function automatic data_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 70) return $urandom_range(0, 3);
    if (r < 78) return 32'h8000_0000;
    if (r < 86) return 32'h7fff_ffff;
    if (r < 94) return 32'hffff_ffff;
    return '0;
  endfunction

  // Op mix leans toward inserts or deletes so the length sweeps empty to full
  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    if (shadow_len >= CAPACITY) fill_mode = 1'b0;
    else if (shadow_len == 0) fill_mode = 1'b1;
    else if ($urandom_range(0, 49) == 0) fill_mode = ~fill_mode;
    r = $urandom_range(0, 99);
    if (fill_mode) begin
      if (r < 30) return OP_INSERT_AT;
      if (r < 45) return OP_INSERT_KEY;
      if (r < 55) return OP_DELETE_AT;
      if (r < 63) return OP_DELETE_FIRST;
      if (r < 68) return OP_DELETE_ALL;
      if (r < 82) return OP_READ_AT;
      if (r < 97) return OP_WRITE_AT;
    end else begin
      if (r < 10) return OP_INSERT_AT;
      if (r < 18) return OP_INSERT_KEY;
      if (r < 43) return OP_DELETE_AT;
      if (r < 61) return OP_DELETE_FIRST;
      if (r < 70) return OP_DELETE_ALL;
      if (r < 84) return OP_READ_AT;
      if (r < 97) return OP_WRITE_AT;
    end
    return OP_UNUSED;
  endfunction

  task automatic test_random_traffic(int unsigned n_items, bit with_idle);
    logic [OP_W-1:0] op;
    pos_t            pos;
    data_t           key;
    data_t           val;
    idle_on = with_idle;
    repeat (n_items) begin
      op = pick_op();
      // mostly in range, sometimes anywhere in the field
      if ($urandom_range(0, 99) < 80) pos = pos_t'($urandom_range(0, shadow_len));
      else pos = pos_t'($urandom_range(0, 15));
      // keys usually taken from the list so searches hit
      if (shadow_len != 0 && $urandom_range(0, 99) < 65)
        key = shadow_entries[$urandom_range(0, shadow_len - 1)];
      else
        key = pick_word();
      val = pick_word();
      send_request(op, pos, key, val);
    end
    settle_list();
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b1;
    fill_mode     = 1'b1;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    shadow_len    = 0;
    for (int i = 0; i < CAPACITY; i++) shadow_entries[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_bounds_and_keys();
    test_random_traffic(500, 1'b1);
    test_random_traffic(200, 1'b0);
    test_random_traffic(575, 1'b1);

    if (expected_results_q.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_results_q.size()));
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bal_pkg.sv
rtl/bal_ram.sv
rtl/bal_ctrl.sv
rtl/bal_dpath.sv
rtl/bounded_array_list_engine.sv
verif/tb_top.sv
